### sv/ahfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfe_pkg
// Shared types, constants and helpers of the ASCII-hex frame encoder.
// ----------------------------------------------------------------------------
package ahfe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_START = 8'h3E;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPA   = 8'h41;
  localparam logic [3:0] NIB_TEN    = 4'hA;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] sum;
    logic       first;
    logic       last;
  } ahfe_job_t;

  typedef enum logic [2:0] {
    PH_BEGIN,
    PH_START,
    PH_HI,
    PH_LO,
    PH_SUM_HI,
    PH_SUM_LO,
    PH_LF
  } ahfe_phase_t;

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    logic [7:0] ext;
    ext = {4'h0, v};
    if (v >= NIB_TEN) begin
      return CHAR_UPA + ext - {4'h0, NIB_TEN};
    end
    return CHAR_ZERO + ext;
  endfunction

endpackage
`default_nettype wire

### sv/ahfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfe_queue
// Small job FIFO between the classifying front end and the character back end.
// ----------------------------------------------------------------------------
module ahfe_queue #(
  parameter int unsigned DEPTH = ahfe_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  ahfe_pkg::ahfe_job_t push_job,
  output logic                can_push,
  input  wire                 pop,
  output ahfe_pkg::ahfe_job_t head_job,
  output logic                head_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ahfe_pkg::ahfe_job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign can_push   = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && can_push;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/ahfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfe_front
// Accepts message bytes, marks first/last and keeps the running checksum.
// ----------------------------------------------------------------------------
module ahfe_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_tdata,
  input  wire                 in_tlast,
  output logic                push,
  output ahfe_pkg::ahfe_job_t push_job,
  input  wire                 can_push
);

  logic       in_message_r, in_message_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_base;
  logic       beat;

  assign in_tready = can_push;
  assign beat      = in_tvalid && can_push;
  assign push      = beat;
  assign sum_base  = in_message_r ? sum_r : 8'h00;

  always_comb begin
    push_job.data  = in_tdata;
    push_job.sum   = sum_base - in_tdata;
    push_job.first = !in_message_r;
    push_job.last  = in_tlast;
    in_message_nxt = in_message_r;
    sum_nxt        = sum_r;
    if (beat) begin
      in_message_nxt = !in_tlast;
      sum_nxt        = in_tlast ? 8'h00 : push_job.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r <= 1'b0;
      sum_r        <= 8'h00;
    end else begin
      in_message_r <= in_message_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/ahfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfe_back
// Turns queued jobs into frame chars in an output reg, one per unstalled cycle.
// ----------------------------------------------------------------------------
module ahfe_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ahfe_pkg::ahfe_job_t head_job,
  input  wire                 head_valid,
  output logic                pop,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  ahfe_pkg::ahfe_phase_t phase_r, phase_nxt, cur;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       load;
  logic [7:0] ch;
  logic       done;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign load       = head_valid && (!out_valid_r || out_tready);
  assign pop        = load && done;

  always_comb begin
    cur = phase_r;
    if (phase_r == ahfe_pkg::PH_BEGIN) begin
      cur = head_job.first ? ahfe_pkg::PH_START : ahfe_pkg::PH_HI;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      unique case (cur)
        ahfe_pkg::PH_BEGIN:  phase_nxt = ahfe_pkg::PH_HI;
        ahfe_pkg::PH_START:  phase_nxt = ahfe_pkg::PH_HI;
        ahfe_pkg::PH_HI:     phase_nxt = ahfe_pkg::PH_LO;
        ahfe_pkg::PH_LO:     phase_nxt = head_job.last ? ahfe_pkg::PH_SUM_HI
                                                       : ahfe_pkg::PH_BEGIN;
        ahfe_pkg::PH_SUM_HI: phase_nxt = ahfe_pkg::PH_SUM_LO;
        ahfe_pkg::PH_SUM_LO: phase_nxt = ahfe_pkg::PH_LF;
        ahfe_pkg::PH_LF:     phase_nxt = ahfe_pkg::PH_BEGIN;
        default:             phase_nxt = ahfe_pkg::PH_BEGIN;
      endcase
    end
  end

  // character for the current phase
  always_comb begin
    ch   = ahfe_pkg::CHAR_LF;
    done = 1'b0;
    unique case (cur)
      ahfe_pkg::PH_BEGIN:  ch = ahfe_pkg::CHAR_START;
      ahfe_pkg::PH_START:  ch = ahfe_pkg::CHAR_START;
      ahfe_pkg::PH_HI:     ch = ahfe_pkg::nibble_char(head_job.data[7:4]);
      ahfe_pkg::PH_LO: begin
        ch   = ahfe_pkg::nibble_char(head_job.data[3:0]);
        done = !head_job.last;
      end
      ahfe_pkg::PH_SUM_HI: ch = ahfe_pkg::nibble_char(head_job.sum[7:4]);
      ahfe_pkg::PH_SUM_LO: ch = ahfe_pkg::nibble_char(head_job.sum[3:0]);
      ahfe_pkg::PH_LF: begin
        ch   = ahfe_pkg::CHAR_LF;
        done = 1'b1;
      end
      default:             ch = ahfe_pkg::CHAR_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= ch;
      out_last_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ahfe_pkg::PH_BEGIN;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/ascii_hex_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder_unit
// Each accepted beat is queued as a job; its characters leave via an output reg.
// Throughput: one output character per cycle unless the queue is empty or
// out_tready stalls (output register rate).
// The job queue lets the next bytes be accepted while characters drain.
// Reset: synchronous active-low rst_n clears message state, queue and output.
// ----------------------------------------------------------------------------
module ascii_hex_frame_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = ahfe_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] data_byte
  input  wire        in_tlast,   // last_byte
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // run_last
);

  ahfe_pkg::ahfe_job_t push_job, head_job;
  logic push, can_push, pop, head_valid;

  ahfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .push     (push),
    .push_job (push_job),
    .can_push (can_push)
  );

  ahfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .can_push  (can_push),
    .pop       (pop),
    .head_job  (head_job),
    .head_valid(head_valid)
  );

  ahfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .head_valid(head_valid),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire
